>>> rtl/sme_pkg.sv
// Shared types, opcodes, status codes and sizes for the stack machine executor.
package sme_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned DCNT_W      = $clog2(DIV_STEPS);

  localparam logic [7:0] OPC_HALT  = 8'd0;
  localparam logic [7:0] OPC_PUSHC = 8'd1;
  localparam logic [7:0] OPC_ADD   = 8'd2;
  localparam logic [7:0] OPC_SUB   = 8'd3;
  localparam logic [7:0] OPC_MUL   = 8'd4;
  localparam logic [7:0] OPC_DIV   = 8'd5;
  localparam logic [7:0] OPC_MOD   = 8'd6;
  localparam logic [7:0] OPC_RDINT = 8'd7;
  localparam logic [7:0] OPC_WRINT = 8'd8;
  localparam logic [7:0] OPC_RDCHR = 8'd9;
  localparam logic [7:0] OPC_WRCHR = 8'd10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HALTED    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;
  localparam logic [2:0] ST_UNKNOWN   = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_CHR  = 2'd2;

  typedef enum logic [3:0] {
    OP_HALT,
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_WRINT,
    OP_WRCHR,
    OP_BAD
  } op_class_e;

  typedef struct packed {
    logic        [31:0] instruction;
    logic signed [31:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic        [1:0]  out_kind;
    logic signed [31:0] out_value;
  } out_item_t;

  typedef struct packed {
    op_class_e   op;
    logic [31:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic               halted;
    logic [DEPTH_W-1:0] depth;
  } stat_t;

endpackage

>>> rtl/sme_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sme_front.sv
// Front end: accepts items, decodes them into commands and queues them for the back end.
module sme_front
  import sme_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t              cmd_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  cmd_t              dec;
  logic              push;
  logic              pop;

  always_comb begin
    dec.op         = OP_BAD;
    dec.push_value = '0;
    unique case (in_item_i.instruction[31:24])
      OPC_HALT:  dec.op = OP_HALT;
      OPC_PUSHC: begin
        dec.op         = OP_PUSH;
        dec.push_value = {{8{in_item_i.instruction[23]}}, in_item_i.instruction[23:0]};
      end
      OPC_RDINT: begin
        dec.op         = OP_PUSH;
        dec.push_value = in_item_i.read_value;
      end
      OPC_RDCHR: begin
        dec.op         = OP_PUSH;
        dec.push_value = {{24{in_item_i.read_value[7]}}, in_item_i.read_value[7:0]};
      end
      OPC_ADD:   dec.op = OP_ADD;
      OPC_SUB:   dec.op = OP_SUB;
      OPC_MUL:   dec.op = OP_MUL;
      OPC_DIV:   dec.op = OP_DIV;
      OPC_MOD:   dec.op = OP_MOD;
      OPC_WRINT: dec.op = OP_WRINT;
      OPC_WRCHR: dec.op = OP_WRCHR;
      default:   dec.op = OP_BAD;
    endcase
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wptr_q] <= dec;
    end
  end

endmodule

>>> rtl/sme_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sme_div
  import sme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [31:0]       quo_q;
  logic [31:0]       rem_q;
  logic [31:0]       dvs_q;
  logic              qneg_q;
  logic              rneg_q;
  logic [32:0]       shifted;
  logic [32:0]       diff;
  logic [31:0]       a_mag;
  logic [31:0]       b_mag;

  assign a_mag   = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
  assign b_mag   = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= a_mag;
      rem_q  <= '0;
      dvs_q  <= b_mag;
      qneg_q <= dividend_i[31] ^ divisor_i[31];
      rneg_q <= dividend_i[31];
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], ~diff[32]};
      rem_q <= diff[32] ? shifted[31:0] : diff[31:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = qneg_q ? (32'd0 - quo_q) : quo_q;
  assign remainder_o = rneg_q ? (32'd0 - rem_q) : rem_q;

endmodule

>>> rtl/sme_back.sv
// Back end: executes queued commands on the stack and registers one result per item.
module sme_back
  import sme_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  output stat_t     stat_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIN,
    S_DIV,
    S_RELOAD
  } state_e;

  state_e             state_q, state_d;
  op_class_e          op_q, op_d;
  logic [31:0]        tos_q, tos_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               halted_q, halted_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  logic [DEPTH_W-1:0] depth_m1;
  logic [DEPTH_W-1:0] depth_m2;
  logic               out_free;
  logic               ram_we;
  logic               ram_re;
  logic [31:0]        ram_rdata;
  logic [31:0]        alu_res;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quo;
  logic [31:0]        div_rem;

  assign depth_m1 = depth_q - 1'b1;
  assign depth_m2 = depth_q - 2'd2;
  assign out_free = !out_valid_q || out_ready_i;

  sme_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(depth_m1[ADDR_W-1:0]),
    .wdata_i(tos_q),
    .re_i   (ram_re),
    .raddr_i(depth_m2[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  sme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ram_rdata),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    case (op_q)
      OP_ADD:  alu_res = ram_rdata + tos_q;
      OP_SUB:  alu_res = ram_rdata - tos_q;
      default: alu_res = ram_rdata * tos_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    tos_d       = tos_q;
    depth_d     = depth_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    cmd_pop_o   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o  = 1'b1;
          op_d       = cmd_i.op;
          out_item_d = '{status: ST_OK, out_kind: KIND_NONE, out_value: '0};
          if (halted_q) begin
            out_valid_d       = 1'b1;
            out_item_d.status = ST_HALTED;
          end else begin
            unique case (cmd_i.op) inside
              OP_HALT: begin
                out_valid_d       = 1'b1;
                halted_d          = 1'b1;
                out_item_d.status = ST_HALTED;
              end
              OP_PUSH: begin
                out_valid_d = 1'b1;
                if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
                  halted_d          = 1'b1;
                  out_item_d.status = ST_OVERFLOW;
                end else begin
                  ram_we  = (depth_q != '0);
                  tos_d   = cmd_i.push_value;
                  depth_d = depth_q + 1'b1;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (depth_q < DEPTH_W'(2)) begin
                  out_valid_d       = 1'b1;
                  halted_d          = 1'b1;
                  out_item_d.status = ST_UNDERFLOW;
                end else if ((cmd_i.op == OP_DIV || cmd_i.op == OP_MOD) && tos_q == '0) begin
                  out_valid_d       = 1'b1;
                  halted_d          = 1'b1;
                  out_item_d.status = ST_DIVZERO;
                end else begin
                  ram_re  = 1'b1;
                  state_d = S_BIN;
                end
              end
              OP_WRINT, OP_WRCHR: begin
                out_valid_d = 1'b1;
                if (depth_q == '0) begin
                  halted_d          = 1'b1;
                  out_item_d.status = ST_UNDERFLOW;
                end else begin
                  out_item_d.out_kind  = (cmd_i.op == OP_WRINT) ? KIND_INT : KIND_CHR;
                  out_item_d.out_value = tos_q;
                  depth_d              = depth_m1;
                  if (depth_q >= DEPTH_W'(2)) begin
                    ram_re  = 1'b1;
                    state_d = S_RELOAD;
                  end
                end
              end
              default: begin
                out_valid_d       = 1'b1;
                out_item_d.status = ST_UNKNOWN;
              end
            endcase
          end
        end
      end
      S_BIN: begin
        if (op_q == OP_DIV || op_q == OP_MOD) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          tos_d       = alu_res;
          depth_d     = depth_m1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          tos_d       = (op_q == OP_DIV) ? div_quo : div_rem;
          depth_d     = depth_m1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RELOAD: begin
        tos_d   = ram_rdata;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_BAD;
      tos_q       <= '0;
      depth_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      tos_q       <= tos_d;
      depth_q     <= depth_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_item_o    = out_item_q;
  assign stat_o.halted = halted_q;
  assign stat_o.depth  = depth_q;

endmodule

>>> rtl/stack_machine_executor.sv
// Top level of the stack machine executor: front end, command queue and back end.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_item_i  (instruction, read_value)
//   out     | output    | out_valid_o / out_ready_i| out_item_o (status, out_kind, out_value)
//
// Pushes, HALT, unknown opcodes, halted items and writes from a one-deep stack complete in the idle state.
// ADD, SUB, MUL and writes from a deeper stack first read the stack RAM, then execute in a second state.
// DIV and MOD read the stack RAM, then wait on the divider, which resolves one quotient bit per cycle.
// A two-entry command queue decouples input acceptance from execution.
// Reset clears the stack depth and the halted flag; the stack RAM itself is not cleared.
// The back end starts an item only when the result register is free or being drained.
module stack_machine_executor
  import sme_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic  cmd_valid;
  cmd_t  cmd;
  logic  cmd_pop;
  stat_t stat;

  sme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  sme_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .stat_o     (stat)
  );

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.depth <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.halted |=> stat.halted)
    else $error("halted flag cleared");

  a_halt_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stat.halted) |-> out_valid_o && out_item_o.status != ST_OK)
    else $error("halt without a reporting item");

  a_depth_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.depth == $past(stat.depth) || stat.depth == $past(stat.depth) + 1'b1 ||
    stat.depth == $past(stat.depth) - 1'b1)
    else $error("stack depth moved by more than one");

endmodule
